// File: hdl/ism_pkg.sv
// Shared types and constants for the integer stack machine.
// Depends on nothing; every other file of the block uses it.
package ism_pkg;

  typedef logic signed [31:0] word_t;
  typedef logic [2:0]         op_t;
  typedef logic [2:0]         status_t;

  localparam op_t OP_PUSH = 3'd0;
  localparam op_t OP_POP  = 3'd1;
  localparam op_t OP_SWAP = 3'd2;
  localparam op_t OP_ADD  = 3'd3;
  localparam op_t OP_LIST = 3'd4;

  localparam status_t ST_OK         = 3'd0;
  localparam status_t ST_EMPTY_POP  = 3'd1;
  localparam status_t ST_SHORT      = 3'd2;
  localparam status_t ST_OVERFLOW   = 3'd3;
  localparam status_t ST_EMPTY_LIST = 3'd4;

  // Source that a cell loads from at a clock edge.
  typedef logic [1:0] sel_t;
  localparam sel_t SEL_HOLD  = 2'd0;
  localparam sel_t SEL_ABOVE = 2'd1;
  localparam sel_t SEL_BELOW = 2'd2;
  localparam sel_t SEL_WRAP  = 2'd3;

  // Control handed to each cell.
  typedef struct packed {
    sel_t sel;
  } cell_ctrl_t;

endpackage

// File: hdl/ism_cmd_if.sv
// Instruction channel of the integer stack machine: valid/ready plus payload.
// Depends on ism_pkg.
interface ism_cmd_if;
  logic                valid;
  logic                ready;
  ism_pkg::op_t        op;
  ism_pkg::word_t      push_value;

  modport source(output valid, output op, output push_value, input ready);
  modport sink(input valid, input op, input push_value, output ready);
endinterface

// File: hdl/ism_res_if.sv
// Result channel of the integer stack machine: valid/ready plus payload.
// Depends on ism_pkg.
interface ism_res_if;
  logic                valid;
  logic                ready;
  ism_pkg::word_t      word;
  ism_pkg::status_t    status;
  logic                last;

  modport source(output valid, output word, output status, output last, input ready);
  modport sink(input valid, input word, input status, input last, output ready);
endinterface

// File: hdl/ism_cell.sv
// One stack cell: holds a single entry and loads from its upper or lower
// neighbor, from the top cell, or holds. Depends on ism_pkg.
module ism_cell (
  input  logic                clk,
  input  ism_pkg::cell_ctrl_t ctrl,
  input  ism_pkg::word_t      above_word,
  input  ism_pkg::word_t      below_word,
  input  ism_pkg::word_t      wrap_word,
  output ism_pkg::word_t      word
);

  ism_pkg::word_t value;

  always_ff @(posedge clk) begin
    case (ctrl.sel)
      ism_pkg::SEL_HOLD:  value <= value;
      ism_pkg::SEL_ABOVE: value <= above_word;
      ism_pkg::SEL_BELOW: value <= below_word;
      ism_pkg::SEL_WRAP:  value <= wrap_word;
      default:            value <= value;
    endcase
  end

  assign word = value;

endmodule

// File: hdl/integer_stack_machine_unit.sv
// Integer stack machine: a bounded stack of 32-bit words kept in a row of cells.
// Cell 0 holds the top entry. Depends on ism_pkg, ism_cmd_if, ism_res_if, ism_cell.
//
// Usage:
//   cmd carries one instruction word (op, push_value); res returns result
//   words (word, status, last). Both use valid/ready; a word moves at a
//   clock edge where both are high.
//   Push, pop, swap and add answer at once: the result word is registered at
//   the accepting edge and shows on res in the next cycle, so with res.ready
//   held high one such instruction is taken every cycle.
//   A list of n entries starts when taken, then gives one entry per cycle
//   while res is not stalled, top first, with last set on the bottom entry.
//   The chain rotates by one cell per listed entry, so after n steps the
//   stack is back in order. cmd.ready is low while a list is running. A list
//   on an empty stack gives one empty-listing status word in the next cycle.
//   When res stalls, the output register holds its word; cmd.ready stays high
//   only if that word is taken in the same cycle, and listing pauses.
//   Reset (rst, synchronous) empties the stack and drops res.valid; the cell
//   contents are not cleared, since entries above the count are never shown.
module integer_stack_machine_unit #(
  parameter int STACK_DEPTH = 64
) (
  input  logic           clk,
  input  logic           rst,
  ism_cmd_if.sink        cmd,
  ism_res_if.source      res
);

  localparam int CW = $clog2(STACK_DEPTH + 1);

  ism_pkg::word_t      cells [STACK_DEPTH];
  ism_pkg::cell_ctrl_t ctrl  [STACK_DEPTH];

  logic [CW-1:0]       count;
  logic [CW-1:0]       count_next;
  logic [CW-1:0]       remain;
  logic                listing;

  logic                out_valid;
  ism_pkg::word_t      out_word;
  ism_pkg::status_t    out_status;
  logic                out_last;

  logic                out_free;
  logic                accept;
  logic                list_step;
  logic                is_empty;
  logic                has_two;
  logic                is_full;
  ism_pkg::word_t      top_word;
  ism_pkg::word_t      sum_word;
  ism_pkg::word_t      load_word;
  ism_pkg::word_t      res_word_next;
  ism_pkg::status_t    res_status_next;

  assign out_free  = !out_valid || res.ready;
  assign cmd.ready = !listing && out_free;
  assign accept    = cmd.valid && cmd.ready;
  assign list_step = listing && out_free;

  assign is_empty  = (count == '0);
  assign has_two   = (count >= CW'(2));
  assign is_full   = (count >= CW'(STACK_DEPTH));
  assign top_word  = is_empty ? '0 : cells[0];
  assign sum_word  = cells[0] + cells[1];
  assign load_word = (cmd.op == ism_pkg::OP_ADD) ? sum_word : cmd.push_value;

  // Per-cell load selection.
  always_comb begin
    for (int i = 0; i < STACK_DEPTH; i++) begin
      ctrl[i].sel = ism_pkg::SEL_HOLD;
      if (accept) begin
        case (cmd.op)
          ism_pkg::OP_PUSH: if (!is_full)  ctrl[i].sel = ism_pkg::SEL_ABOVE;
          ism_pkg::OP_POP:  if (!is_empty) ctrl[i].sel = ism_pkg::SEL_BELOW;
          ism_pkg::OP_SWAP: begin
            if (has_two && i == 0) ctrl[i].sel = ism_pkg::SEL_BELOW;
            if (has_two && i == 1) ctrl[i].sel = ism_pkg::SEL_ABOVE;
          end
          ism_pkg::OP_ADD: begin
            if (has_two) ctrl[i].sel = (i == 0) ? ism_pkg::SEL_ABOVE : ism_pkg::SEL_BELOW;
          end
          default: ctrl[i].sel = ism_pkg::SEL_HOLD;
        endcase
      end else if (list_step) begin
        // The bottom valid cell takes the old top, closing the rotation.
        ctrl[i].sel = (count == CW'(i + 1)) ? ism_pkg::SEL_WRAP : ism_pkg::SEL_BELOW;
      end
    end
  end

  for (genvar g = 0; g < STACK_DEPTH; g++) begin : g_cell
    ism_cell u_cell (
      .clk        (clk),
      .ctrl       (ctrl[g]),
      .above_word ((g == 0) ? load_word : cells[(g == 0) ? 0 : g - 1]),
      .below_word ((g == STACK_DEPTH - 1) ? ism_pkg::word_t'(0)
                                          : cells[(g == STACK_DEPTH - 1) ? g : g + 1]),
      .wrap_word  (cells[0]),
      .word       (cells[g])
    );
  end

  // Result and new count of a non-list instruction.
  always_comb begin
    res_word_next   = top_word;
    res_status_next = ism_pkg::ST_OK;
    count_next      = count;
    case (cmd.op)
      ism_pkg::OP_PUSH: begin
        if (is_full) begin
          res_status_next = ism_pkg::ST_OVERFLOW;
        end else begin
          res_word_next = cmd.push_value;
          count_next    = count + CW'(1);
        end
      end
      ism_pkg::OP_POP: begin
        if (is_empty) begin
          res_status_next = ism_pkg::ST_EMPTY_POP;
        end else begin
          res_word_next = has_two ? cells[1] : '0;
          count_next    = count - CW'(1);
        end
      end
      ism_pkg::OP_SWAP: begin
        if (!has_two) res_status_next = ism_pkg::ST_SHORT;
        else          res_word_next   = cells[1];
      end
      ism_pkg::OP_ADD: begin
        if (!has_two) begin
          res_status_next = ism_pkg::ST_SHORT;
        end else begin
          res_word_next = sum_word;
          count_next    = count - CW'(1);
        end
      end
      default: begin
        res_word_next   = top_word;
        res_status_next = ism_pkg::ST_OK;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      listing   <= 1'b0;
      remain    <= '0;
      count     <= '0;
    end else begin
      // A word stays while stalled, and a new one comes from an instruction
      // that answers at once or from a listing step.
      out_valid <= (out_valid && !res.ready)
                 || (accept && (cmd.op != ism_pkg::OP_LIST || is_empty))
                 || list_step;
      if (accept) begin
        if (cmd.op == ism_pkg::OP_LIST) begin
          if (!is_empty) begin
            listing <= 1'b1;
            remain  <= count;
          end
        end else begin
          count <= count_next;
        end
      end
      if (list_step) begin
        remain <= remain - CW'(1);
        if (remain == CW'(1)) listing <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      if (cmd.op == ism_pkg::OP_LIST) begin
        out_word   <= '0;
        out_status <= ism_pkg::ST_EMPTY_LIST;
        out_last   <= 1'b1;
      end else begin
        out_word   <= res_word_next;
        out_status <= res_status_next;
        out_last   <= 1'b1;
      end
    end else if (list_step) begin
      out_word   <= cells[0];
      out_status <= ism_pkg::ST_OK;
      out_last   <= (remain == CW'(1));
    end
  end

  assign res.valid  = out_valid;
  assign res.word   = out_word;
  assign res.status = out_status;
  assign res.last   = out_last;

endmodule

// File: hdl/ism_checker.sv
// Port-level checks for integer_stack_machine_unit, attached with a bind.
// Depends on ism_pkg and the top level's interface ports.
module ism_checker (
  input logic             clk,
  input logic             rst,
  input logic             cmd_valid,
  input logic             cmd_ready,
  input logic             res_valid,
  input logic             res_ready,
  input ism_pkg::word_t   res_word,
  input ism_pkg::status_t res_status,
  input logic             res_last
);

  // A word that is not taken stays on the port unchanged.
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res_word) && $stable(res_last))
    else $error("result word changed while stalled");

  // No instruction is taken while a listing is still going out.
  a_no_cmd_in_list: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_last |-> !(cmd_valid && cmd_ready))
    else $error("instruction accepted in the middle of a listing");

  // Error statuses only come as the single word of their instruction.
  a_err_last: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_status != ism_pkg::ST_OK |-> res_last)
    else $error("error status on a word that is not the last");

  // Empty-stack results carry a zero word.
  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && (res_status == ism_pkg::ST_EMPTY_POP ||
                  res_status == ism_pkg::ST_EMPTY_LIST) |-> res_word == '0)
    else $error("empty-stack result with a nonzero word");

  // Reset leaves no result pending.
  a_reset_idle: assert property (@(posedge clk) rst |=> !res_valid)
    else $error("result valid right after reset");

endmodule

bind integer_stack_machine_unit ism_checker u_ism_checker (
  .clk        (clk),
  .rst        (rst),
  .cmd_valid  (cmd.valid),
  .cmd_ready  (cmd.ready),
  .res_valid  (res.valid),
  .res_ready  (res.ready),
  .res_word   (res.word),
  .res_status (res.status),
  .res_last   (res.last)
);
